// ===== hdl/qeacc_pkg.sv =====
// Package for the quadrature encoder decoder with speed-dependent step.
// Holds widths, detent patterns, register indexes and step types.
// No dependencies.
package qeacc_pkg;

  localparam int unsigned CODE_W    = 2;
  localparam int unsigned HIST_W    = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // History (oldest code in bits 7:6): 3,1,0,2 forward and 3,2,0,1 reverse
  localparam logic [HIST_W-1:0] HIST_FWD = 8'b1101_0010;
  localparam logic [HIST_W-1:0] HIST_REV = 8'b1110_0001;

  localparam logic [THR_W-1:0] FAST_THR_RST   = 16'd20;
  localparam logic [THR_W-1:0] MEDIUM_THR_RST = 16'd30;

  typedef logic signed [STEP_W-1:0] step_t;

  localparam step_t MAG_FAST   = 5'sd10;
  localparam step_t MAG_MEDIUM = 5'sd5;
  localparam step_t MAG_SLOW   = 5'sd1;
  localparam step_t STEP_NONE  = 5'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_THR   = 1'b0,
    CFG_MEDIUM_THR = 1'b1
  } cfg_idx_e;

endpackage

// ===== hdl/quadrature_encoder_with_acceleration_core.sv =====
// Top level of the quadrature encoder decoder with speed-dependent step size.
// Depends on qeacc_pkg (hdl/qeacc_pkg.sv).
//
// One beat in per encoder sample (phase A, phase B, millisecond time) and one
// beat out per sample carrying a signed step: 0 unless the last four distinct
// codes form a full detent (3,1,0,2 forward, 3,2,0,1 reverse), then +-10,
// +-5 or +-1 depending on how long ago the previous detent was, compared with
// the fast and medium thresholds (register 0 and 1, reset 20 and 30 ms).
// Throughput is one sample per clock while in_stall_o is low: the code history
// and the last detent time update in the accepting cycle, and the step is
// registered. A two-entry output stage (result register plus skid register)
// keeps the input open while a result waits; the input stalls only when both
// entries are full. Write the thresholds only while no beat is in flight.
module quadrature_encoder_with_acceleration_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [qeacc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [qeacc_pkg::THR_W-1:0]        cfg_wdata_i,
  // sample input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               phase_a_i,
  input  logic                               phase_b_i,
  input  logic [qeacc_pkg::TIME_W-1:0]       now_ms_i,
  // step output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output qeacc_pkg::step_t                   step_o
);
  import qeacc_pkg::*;

  logic [THR_W-1:0]  fast_thr_q, medium_thr_q;
  logic [HIST_W-1:0] hist_q, hist_d;
  logic [TIME_W-1:0] last_det_q, last_det_d;

  logic              out_valid_q, skid_valid_q;
  step_t             out_step_q, skid_step_q;

  logic              in_acc, out_take;
  logic [CODE_W-1:0] code;
  logic [HIST_W-1:0] hist_shift;
  logic              changed, is_fwd, is_rev, is_det;
  logic [TIME_W-1:0] interval;
  logic              hi_zero;
  step_t             mag, step_new;

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign step_o      = out_step_q;

  assign in_acc   = in_valid_i & ~skid_valid_q;
  assign out_take = out_valid_q & ~out_stall_i;

  // ---- decode ----
  assign code       = {phase_b_i, phase_a_i};
  assign changed    = (code != hist_q[CODE_W-1:0]);
  assign hist_shift = {hist_q[HIST_W-CODE_W-1:0], code};
  assign is_fwd     = changed && (hist_shift == HIST_FWD);
  assign is_rev     = changed && (hist_shift == HIST_REV);
  assign is_det     = is_fwd | is_rev;

  // interval since previous detent, mod 2^32; thresholds are 16 bits wide
  assign interval = now_ms_i - last_det_q;
  assign hi_zero  = (interval[TIME_W-1:THR_W] == '0);

  always_comb begin
    if (hi_zero && (interval[THR_W-1:0] < fast_thr_q)) begin
      mag = MAG_FAST;
    end else if (hi_zero && (interval[THR_W-1:0] < medium_thr_q)) begin
      mag = MAG_MEDIUM;
    end else begin
      mag = MAG_SLOW;
    end
  end

  always_comb begin
    step_new = STEP_NONE;
    if (is_fwd) begin
      step_new = mag;
    end else if (is_rev) begin
      step_new = -mag;
    end
  end

  always_comb begin
    hist_d     = hist_q;
    last_det_d = last_det_q;
    if (in_acc && changed) begin
      hist_d = hist_shift;
    end
    if (in_acc && is_det) begin
      last_det_d = now_ms_i;
    end
  end

  // ---- state and config ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q       <= '0;
      last_det_q   <= '0;
      fast_thr_q   <= FAST_THR_RST;
      medium_thr_q <= MEDIUM_THR_RST;
    end else begin
      hist_q     <= hist_d;
      last_det_q <= last_det_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FAST_THR:   fast_thr_q   <= cfg_wdata_i;
          CFG_MEDIUM_THR: medium_thr_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // ---- output register and skid ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_take || !out_valid_q) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_step_q <= skid_step_q;
      end else if (in_acc) begin
        out_step_q <= step_new;
      end
    end else if (in_acc) begin
      skid_step_q <= step_new;
    end
  end

`ifndef SYNTH
  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output entry");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_stall_i) && $past(out_valid_q))
    else $error("skid filled while output was free");

  a_step_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_step_q == STEP_NONE) || (out_step_q == MAG_SLOW) ||
                    (out_step_q == MAG_MEDIUM) || (out_step_q == MAG_FAST) ||
                    (out_step_q == -MAG_SLOW) || (out_step_q == -MAG_MEDIUM) ||
                    (out_step_q == -MAG_FAST))
    else $error("illegal step value");

  a_time_only_on_detent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_det_q != $past(last_det_q)) |-> $past(in_acc) && $past(is_det))
    else $error("detent time changed without a detent");
`endif

endmodule
